@@ hw/rtl/tmp_pkg.sv @@
// Shared types, constants and helpers for the trapezoidal motion profile unit.
package tmp_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_INDEX_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_VELOCITY = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_RATE    = 8'd1;

  localparam logic [30:0] PEAK_VELOCITY_RST = 31'd65536;
  localparam logic [30:0] ACCEL_RATE_RST    = 31'd65536;

  typedef enum logic [1:0] {
    PH_ACCEL   = 2'd0,
    PH_CRUISE  = 2'd1,
    PH_DECEL   = 2'd2,
    PH_ARRIVED = 2'd3
  } phase_t;

  // per-word context carried down the pipeline
  typedef struct packed {
    logic [31:0] st;    // start angle
    logic [31:0] gl;    // goal angle
    logic [31:0] t;     // elapsed time
    logic [31:0] d;     // |goal - start|
    logic        up;    // goal >= start
    logic        trap;  // trapezoid (peak velocity reached)
  } ctx_t;

  function automatic logic [63:0] mul32(input logic [31:0] x, input logic [31:0] y);
    mul32 = {32'd0, x} * {32'd0, y};
  endfunction

endpackage

@@ hw/rtl/trapezoidal_motion_profile_unit.sv @@
// Trapezoidal motion profile unit: pipelined set-point evaluator, top level.
//
// Usage:
//   s_* channel takes one query word per cycle while s_tready is high: start
//   angle, goal angle and elapsed time. m_* channel returns one word per query,
//   in order: the profiled set-point angle (saturated between start and goal)
//   and the phase (accelerate, cruise, decelerate, arrived).
//   cfg_* writes peak_velocity (index 0) or accel_rate (index 1); other
//   indexes are dropped. Write only while no query is in flight. A zero
//   register value acts as 1.
// Depth: set by the 32-stage square root and the 32-stage quotient pipelines,
//   one result bit per stage.
// Throughput: one word per cycle while m_tready stays high.
// Reset: synchronous, clears every valid bit and loads both registers with
//   1.0 (65536 raw at 16 fraction bits). Nothing else needs clearing.
// Stall: when a result waits and m_tready is low the whole pipeline freezes
//   and s_tready drops; no word is dropped or repeated.
module trapezoidal_motion_profile_unit
  import tmp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // query words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [95:0]            s_tdata,   // start_angle, goal_angle, elapsed_time
  // result words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata,   // setpoint_angle, phase, zero pad
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int SH     = 2 * FRACTION_BITS + 1;  // scale of a*x*x/2
  localparam int NSTEPS = 32;                     // root / quotient bits

  // ---------------------------------------------------------------- config
  logic [30:0] peak_velocity;
  logic [30:0] accel_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_velocity <= PEAK_VELOCITY_RST;
      accel_rate    <= ACCEL_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PEAK_VELOCITY: peak_velocity <= cfg_data[30:0];
        REG_ACCEL_RATE:    accel_rate    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // zero register acts as one
  logic [31:0] v_e, a_e;
  assign v_e = (peak_velocity == 31'd0) ? 32'd1 : {1'b0, peak_velocity};
  assign a_e = (accel_rate == 31'd0) ? 32'd1 : {1'b0, accel_rate};

  // ---------------------------------------------------------------- flow
  logic en;
  logic out_v;
  assign m_tvalid = out_v;
  assign en       = !out_v || m_tready;
  assign s_tready = en;

  // ---------------------------------------------------------------- front
  logic        in_v;
  logic [31:0] in_st, in_gl, in_t;
  logic        dif_v;
  ctx_t        dif_c;
  logic        mul_v;
  ctx_t        mul_c;
  logic [63:0] mul_da, mul_vv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      dif_v <= 1'b0;
      mul_v <= 1'b0;
    end else if (en) begin
      in_v  <= s_tvalid;
      dif_v <= in_v;
      mul_v <= dif_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_st <= s_tdata[31:0];
      in_gl <= s_tdata[63:32];
      in_t  <= s_tdata[95:64];

      dif_c.st   <= in_st;
      dif_c.gl   <= in_gl;
      dif_c.t    <= in_t;
      dif_c.up   <= $signed(in_gl) >= $signed(in_st);
      dif_c.d    <= ($signed(in_gl) >= $signed(in_st)) ? in_gl - in_st : in_st - in_gl;
      dif_c.trap <= 1'b0;

      mul_c  <= dif_c;
      mul_da <= mul32(dif_c.d, a_e);
      mul_vv <= mul32(v_e, v_e);
    end
  end

  // ---------------------------------------------------------------- sqrt
  // stage 0 holds the trapezoid decision and the radicand d*a
  logic        sq_v [0:NSTEPS];
  ctx_t        sq_c [0:NSTEPS];
  logic [63:0] sq_n [0:NSTEPS];
  logic [63:0] sq_r [0:NSTEPS];
  ctx_t        mul_cx;

  always_comb begin
    mul_cx      = mul_c;
    mul_cx.trap = mul_da > mul_vv;
  end

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= mul_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c[0] <= mul_cx;
      sq_n[0] <= mul_da;
      sq_r[0] <= 64'd0;
    end
  end

  for (genvar j = 1; j <= NSTEPS; j++) begin : g_sqrt
    logic [63:0] bitv, trial;
    assign bitv  = 64'd1 << (2 * (NSTEPS - j));
    assign trial = sq_r[j-1] + bitv;

    always_ff @(posedge clk) begin
      if (rst) sq_v[j] <= 1'b0;
      else if (en) sq_v[j] <= sq_v[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[j] <= sq_c[j-1];
        if (sq_n[j-1] >= trial) begin
          sq_n[j] <= sq_n[j-1] - trial;
          sq_r[j] <= (sq_r[j-1] >> 1) + bitv;
        end else begin
          sq_n[j] <= sq_n[j-1];
          sq_r[j] <= sq_r[j-1] >> 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- divide
  // qa: ta = (v or p) * 2^F / a,  qe: te = d * 2^F / v; big = quotient >= 2^32
  logic        dv_v    [0:NSTEPS];
  ctx_t        dv_c    [0:NSTEPS];
  logic [31:0] dv_p    [0:NSTEPS];
  logic [63:0] dv_ra   [0:NSTEPS];
  logic [63:0] dv_re   [0:NSTEPS];
  logic [31:0] dv_qa   [0:NSTEPS];
  logic [31:0] dv_qe   [0:NSTEPS];
  logic        dv_biga [0:NSTEPS];
  logic        dv_bige [0:NSTEPS];

  logic [31:0] sq_p;
  logic [63:0] num_a, num_e;
  assign sq_p  = sq_r[NSTEPS][31:0];
  assign num_a = {32'd0, (sq_c[NSTEPS].trap ? v_e : sq_p)} << FRACTION_BITS;
  assign num_e = {32'd0, sq_c[NSTEPS].d} << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[NSTEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c[0]    <= sq_c[NSTEPS];
      dv_p[0]    <= sq_p;
      dv_ra[0]   <= num_a;
      dv_re[0]   <= num_e;
      dv_qa[0]   <= 32'd0;
      dv_qe[0]   <= 32'd0;
      dv_biga[0] <= num_a >= {a_e, 32'd0};
      dv_bige[0] <= num_e >= {v_e, 32'd0};
    end
  end

  for (genvar j = 1; j <= NSTEPS; j++) begin : g_div
    logic [63:0] sub_a, sub_e;
    assign sub_a = {32'd0, a_e} << (NSTEPS - j);
    assign sub_e = {32'd0, v_e} << (NSTEPS - j);

    always_ff @(posedge clk) begin
      if (rst) dv_v[j] <= 1'b0;
      else if (en) dv_v[j] <= dv_v[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c[j]    <= dv_c[j-1];
        dv_p[j]    <= dv_p[j-1];
        dv_biga[j] <= dv_biga[j-1];
        dv_bige[j] <= dv_bige[j-1];
        if (dv_ra[j-1] >= sub_a) begin
          dv_ra[j] <= dv_ra[j-1] - sub_a;
          dv_qa[j] <= {dv_qa[j-1][30:0], 1'b1};
        end else begin
          dv_ra[j] <= dv_ra[j-1];
          dv_qa[j] <= {dv_qa[j-1][30:0], 1'b0};
        end
        if (dv_re[j-1] >= sub_e) begin
          dv_re[j] <= dv_re[j-1] - sub_e;
          dv_qe[j] <= {dv_qe[j-1][30:0], 1'b1};
        end else begin
          dv_re[j] <= dv_re[j-1];
          dv_qe[j] <= {dv_qe[j-1][30:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- phase
  ctx_t        dc;
  logic [31:0] dta, dte;
  logic        dta_big, dte_big;
  phase_t      phase_next;
  assign dc      = dv_c[NSTEPS];
  assign dta     = dv_qa[NSTEPS];
  assign dte     = dv_qe[NSTEPS];
  assign dta_big = dv_biga[NSTEPS];
  assign dte_big = dv_bige[NSTEPS];

  always_comb begin
    if (dta_big || dc.t <= dta) phase_next = PH_ACCEL;
    else if (dc.trap) begin
      if (dte_big || dc.t <= dte) phase_next = PH_CRUISE;
      else if ({1'b0, dc.t} <= {1'b0, dte} + {1'b0, dta}) phase_next = PH_DECEL;
      else phase_next = PH_ARRIVED;
    end else begin
      if ({1'b0, dc.t} <= {dta, 1'b0}) phase_next = PH_DECEL;
      else phase_next = PH_ARRIVED;
    end
  end

  logic        ph_v;
  ctx_t        ph_c;
  phase_t      ph_phase;
  logic [31:0] ph_p, ph_ta, ph_te;

  // operand select
  logic        op_v;
  ctx_t        op_c;
  phase_t      op_phase;
  logic [31:0] op_ta, op_x, op_m1, op_n1, op_n2;
  logic [31:0] x_next, m1_next, n1_next, n2_next;

  always_comb begin
    x_next  = ph_c.t;
    m1_next = 32'd0;
    n1_next = 32'd0;
    n2_next = 32'd0;
    case (ph_phase)
      PH_ACCEL: x_next = ph_c.t;
      PH_CRUISE: begin
        m1_next = v_e;
        n1_next = ph_c.t - ph_ta;
      end
      PH_DECEL: begin
        if (ph_c.trap) begin
          x_next  = ph_c.t - ph_te;
          m1_next = v_e;
          n1_next = ph_te - ph_ta;
          n2_next = ph_c.t - ph_te;
        end else begin
          x_next  = ph_c.t - ph_ta;
          m1_next = ph_p;
          n1_next = ph_c.t - ph_ta;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- multiply
  logic        m1_v;
  ctx_t        m1_c;
  phase_t      m1_phase;
  logic [31:0] m1_ta, m1_x;
  logic [63:0] m1_pata, m1_pax, m1_p1, m1_p2;

  logic        m2_v;
  ctx_t        m2_c;
  phase_t      m2_phase;
  logic [63:0] m2_sal, m2_sah, m2_ql, m2_qh, m2_lin;

  logic        m3_v;
  ctx_t        m3_c;
  phase_t      m3_phase;
  logic [95:0] m3_sa, m3_q;
  logic [63:0] m3_lin;

  logic        m4_v;
  ctx_t        m4_c;
  phase_t      m4_phase;
  logic [63:0] m4_sum;
  logic [95:0] m4_q;

  logic        m5_v;
  ctx_t        m5_c;
  phase_t      m5_phase;
  logic [95:0] m5_s;

  logic        m6_v;
  ctx_t        m6_c;
  phase_t      m6_phase;
  logic [31:0] m6_s;

  logic [31:0] out_sp, out_gl;
  phase_t      out_phase;

  logic [95:0] sa_sh;
  logic [95:0] s_next;
  assign sa_sh = m3_sa >> SH;

  always_comb begin
    case (m4_phase)
      PH_ACCEL:  s_next = m4_q;
      PH_CRUISE: s_next = {32'd0, m4_sum};
      PH_DECEL:  s_next = {32'd0, m4_sum - m4_q[63:0]};
      default:   s_next = 96'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_v  <= 1'b0;
      op_v  <= 1'b0;
      m1_v  <= 1'b0;
      m2_v  <= 1'b0;
      m3_v  <= 1'b0;
      m4_v  <= 1'b0;
      m5_v  <= 1'b0;
      m6_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      ph_v  <= dv_v[NSTEPS];
      op_v  <= ph_v;
      m1_v  <= op_v;
      m2_v  <= m1_v;
      m3_v  <= m2_v;
      m4_v  <= m3_v;
      m5_v  <= m4_v;
      m6_v  <= m5_v;
      out_v <= m6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_c     <= dc;
      ph_phase <= phase_next;
      ph_p     <= dv_p[NSTEPS];
      ph_ta    <= dta;
      ph_te    <= dte;

      op_c     <= ph_c;
      op_phase <= ph_phase;
      op_ta    <= ph_ta;
      op_x     <= x_next;
      op_m1    <= m1_next;
      op_n1    <= n1_next;
      op_n2    <= n2_next;

      m1_c     <= op_c;
      m1_phase <= op_phase;
      m1_ta    <= op_ta;
      m1_x     <= op_x;
      m1_pata  <= mul32(a_e, op_ta);
      m1_pax   <= mul32(a_e, op_x);
      m1_p1    <= mul32(op_m1, op_n1);
      m1_p2    <= mul32(v_e, op_n2);

      // first-stage product split into halves, one 32x32 product each
      m2_c     <= m1_c;
      m2_phase <= m1_phase;
      m2_sal   <= mul32(m1_pata[31:0], m1_ta);
      m2_sah   <= mul32(m1_pata[63:32], m1_ta);
      m2_ql    <= mul32(m1_pax[31:0], m1_x);
      m2_qh    <= mul32(m1_pax[63:32], m1_x);
      m2_lin   <= (m1_p1 >> FRACTION_BITS) + (m1_p2 >> FRACTION_BITS);

      m3_c     <= m2_c;
      m3_phase <= m2_phase;
      m3_sa    <= {m2_sah, 32'd0} + {32'd0, m2_sal};
      m3_q     <= {m2_qh, 32'd0} + {32'd0, m2_ql};
      m3_lin   <= m2_lin;

      m4_c     <= m3_c;
      m4_phase <= m3_phase;
      m4_sum   <= sa_sh[63:0] + m3_lin;
      m4_q     <= m3_q >> SH;

      m5_c     <= m4_c;
      m5_phase <= m4_phase;
      m5_s     <= s_next;

      // clamp distance to the move length
      m6_c     <= m5_c;
      m6_phase <= m5_phase;
      m6_s     <= ((|m5_s[95:32]) || (m5_s[31:0] > m5_c.d)) ? m5_c.d : m5_s[31:0];

      out_phase <= m6_phase;
      out_gl    <= m6_c.gl;
      if (m6_phase == PH_ARRIVED) out_sp <= m6_c.gl;
      else if (m6_c.up)           out_sp <= m6_c.st + m6_s;
      else                        out_sp <= m6_c.st - m6_s;
    end
  end

  assign m_tdata = {6'd0, out_phase, out_sp};

  // ---------------------------------------------------------------- checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_v[NSTEPS] && !dv_biga[NSTEPS] |-> dv_ra[NSTEPS] < {32'd0, a_e})
    else $error("ta quotient remainder not below divisor");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m6_v |-> m6_s <= m6_c.d)
    else $error("distance exceeds move length");

  a_arrived: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_phase == PH_ARRIVED |-> out_sp == out_gl)
    else $error("arrived without holding the goal");

endmodule
